>>> design/mtsl_pkg.sv
// ----------------------------------------------------------------------------
// mtsl_pkg
// Shared types and constants for the MFM track sector locator.
// ----------------------------------------------------------------------------
package mtsl_pkg;

  localparam int unsigned MaxTracksDef = 256;

  localparam logic [10:0] DataSizeRst = 11'd256;

  localparam logic [7:0] IdMark      = 8'hFE;
  localparam logic [7:0] DataMark    = 8'hFB;
  localparam logic [7:0] DelDataMark = 8'hF8;

  localparam logic [7:0] SizeCodeOk  = 8'd1;
  localparam logic [7:0] RecordMax   = 8'd16;

  localparam logic [17:0] LimitGap   = 18'd14;

  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhIdMarks = 3'd1;
  localparam logic [2:0] PhHeader  = 3'd2;
  localparam logic [2:0] PhGap     = 3'd3;
  localparam logic [2:0] PhDMarks  = 3'd4;
  localparam logic [2:0] PhSkip    = 3'd5;

  localparam logic [2:0] HdrRecord = 3'd2;
  localparam logic [2:0] HdrSize   = 3'd3;
  localparam logic [2:0] HdrLast   = 3'd5;

  typedef struct packed {
    logic [7:0]  track_byte;
    logic        is_mark;
    logic [15:0] track_length;
    logic        end_of_track;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  track_index;
    logic [4:0]  sector_number;
    logic [11:0] sector_slot;
    logic [15:0] data_position;
  } out_item_t;

endpackage

>>> design/mtsl_scan.sv
// ----------------------------------------------------------------------------
// mtsl_scan
// Per-byte address mark scanner state and result computation.
// ----------------------------------------------------------------------------
module mtsl_scan import mtsl_pkg::*; #(
  parameter int unsigned MaxTracks = MaxTracksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_item_t    item_i,
  input  logic [10:0] data_size_i,
  output logic        hit_o,
  output out_item_t   result_o
);

  localparam logic [7:0] TrackLast = 8'(MaxTracks - 1);

  logic [2:0]  phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  track_q, track_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  rec_q, rec_d;
  logic [7:0]  size_q, size_d;

  logic [17:0] pos_ext;
  logic [17:0] len_ext;
  logic        start_ok;
  logic        prev_ok;
  logic        rec_ok;
  logic [7:0]  rec_m1;

  assign pos_ext  = 18'(pos_q) + 18'(data_size_i) + LimitGap;
  assign len_ext  = 18'(item_i.track_length);
  assign start_ok = pos_ext < len_ext;
  assign prev_ok  = (pos_q != 16'd0) && ((pos_ext - 18'd1) < len_ext);
  assign rec_ok   = (size_q == SizeCodeOk) && (rec_q != 8'd0) && (rec_q <= RecordMax);
  assign rec_m1   = rec_q - 8'd1;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    track_d = track_q;
    cnt_d   = cnt_q;
    rec_d   = rec_q;
    size_d  = size_q;
    hit_o   = 1'b0;

    result_o.track_index   = track_q;
    result_o.sector_number = rec_q[4:0];
    result_o.sector_slot   = {track_q, rec_m1[3:0]};
    result_o.data_position = pos_q + 16'd1;

    case (phase_q)
      PhHunt: begin
        if (item_i.is_mark && start_ok) begin
          phase_d = PhIdMarks;
        end
      end
      PhIdMarks: begin
        if (!item_i.is_mark) begin
          if (item_i.track_byte == IdMark) begin
            phase_d = PhHeader;
            cnt_d   = 3'd0;
          end else begin
            phase_d = PhHunt;
          end
        end
      end
      PhHeader: begin
        if (cnt_q == HdrRecord) begin
          rec_d = item_i.track_byte;
        end else if (cnt_q == HdrSize) begin
          size_d = item_i.track_byte;
        end
        if (cnt_q >= HdrLast) begin
          cnt_d   = 3'd0;
          phase_d = PhGap;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PhGap: begin
        if (item_i.is_mark) begin
          phase_d = PhDMarks;
        end
      end
      PhDMarks: begin
        if (!item_i.is_mark) begin
          if (item_i.track_byte == DataMark || item_i.track_byte == DelDataMark) begin
            phase_d = PhSkip;
            hit_o   = rec_ok;
          end else if (prev_ok && item_i.track_byte == IdMark) begin
            phase_d = PhHeader;
            cnt_d   = 3'd0;
          end else begin
            phase_d = PhHunt;
          end
        end
      end
      PhSkip: begin
        phase_d = PhHunt;
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase

    if (item_i.end_of_track) begin
      phase_d = PhHunt;
      cnt_d   = 3'd0;
      pos_d   = 16'd0;
      if (track_q < TrackLast) begin
        track_d = track_q + 8'd1;
      end
    end else if (pos_q != 16'hFFFF) begin
      pos_d = pos_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      pos_q   <= 16'd0;
      track_q <= 8'd0;
      cnt_q   <= 3'd0;
      rec_q   <= 8'd0;
      size_q  <= 8'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      track_q <= track_d;
      cnt_q   <= cnt_d;
      rec_q   <= rec_d;
      size_q  <= size_d;
    end
  end

endmodule

>>> design/mfm_track_sector_locator.sv
// ----------------------------------------------------------------------------
// mfm_track_sector_locator
// Scans a stream of decoded MFM track bytes for ID and data address marks
// and reports the track, sector and data start of each valid sector found.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o in_data_i   (in_item_t)
//   out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (data_size)
//
// A new track byte is accepted every cycle unless the input is stalled.
// A found sector appears on the output register in the cycle after its data
// mark is accepted. Reset clears the scan state and sets data_size to 256.
// The input is stalled only while a result is held and the output is stalled.
// ----------------------------------------------------------------------------
module mfm_track_sector_locator import mtsl_pkg::*; #(
  parameter int unsigned MaxTracks = MaxTracksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);

  logic [10:0] data_size_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q;
  logic        accept;
  logic        hit;
  out_item_t   result;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;

  mtsl_scan #(
    .MaxTracks(MaxTracks)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .data_size_i(data_size_q),
    .hit_o      (hit),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_size_q <= DataSizeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      data_size_q <= cfg_data_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && hit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A held result is never overwritten while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result lost or changed under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sector_number >= 5'd1 && out_data_o.sector_number <= 5'd16)
    else $error("sector number out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.sector_slot[11:4] == out_data_o.track_index &&
      out_data_o.sector_slot[3:0] == 4'(out_data_o.sector_number - 5'd1))
    else $error("sector slot inconsistent with track and sector");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

endmodule

>>> tb/tb_mfm_track_sector_locator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mfm_track_sector_locator
// Streams decoded track bytes into the sector locator and checks every
// reported sector against a cycle-free model of the address-mark scan.
// Runs a directed track, then random tracks under four idle and stall
// mixes and several data_size settings, one overlong track and a burst of
// one-byte tracks that drives the track counter into saturation.
// ----------------------------------------------------------------------------
module tb_mfm_track_sector_locator;
  import mtsl_pkg::*;

  class sector_scoreboard;
    logic [10:0] data_size;
    logic [2:0]  scan_state;
    logic [15:0] byte_pos;
    logic [7:0]  track_cnt;
    logic [2:0]  hdr_cnt;
    logic [7:0]  record_id;
    logic [7:0]  size_code;
    out_item_t   sectors_due[$];
    int          mismatches;

    function new();
      data_size  = DataSizeRst;
      scan_state = PhHunt;
      byte_pos   = '0;
      track_cnt  = '0;
      hdr_cnt    = '0;
      record_id  = '0;
      size_code  = '0;
      mismatches = 0;
    endfunction

    function bit below_limit(logic [15:0] pos, logic [15:0] tlen);
      int lim;
      lim = int'(tlen) - int'(data_size) - int'(LimitGap);
      return int'(pos) < lim;
    endfunction

    function int pending();
      return sectors_due.size();
    endfunction

    function void note_byte(in_item_t d);
      out_item_t hit;
      case (scan_state)
        PhHunt: begin
          if (d.is_mark && below_limit(byte_pos, d.track_length)) scan_state = PhIdMarks;
        end
        PhIdMarks: begin
          if (!d.is_mark) begin
            if (d.track_byte == IdMark) begin
              scan_state = PhHeader;
              hdr_cnt = '0;
            end else begin
              scan_state = PhHunt;
            end
          end
        end
        PhHeader: begin
          if (hdr_cnt == HdrRecord) record_id = d.track_byte;
          else if (hdr_cnt == HdrSize) size_code = d.track_byte;
          if (hdr_cnt >= HdrLast) begin
            hdr_cnt = '0;
            scan_state = PhGap;
          end else begin
            hdr_cnt = hdr_cnt + 3'd1;
          end
        end
        PhGap: begin
          if (d.is_mark) scan_state = PhDMarks;
        end
        PhDMarks: begin
          if (!d.is_mark) begin
            if (d.track_byte == DataMark || d.track_byte == DelDataMark) begin
              scan_state = PhSkip;
              if (size_code == SizeCodeOk && record_id >= 8'd1 && record_id <= RecordMax) begin
                hit.track_index   = track_cnt;
                hit.sector_number = record_id[4:0];
                hit.sector_slot   = 12'(int'(track_cnt) * 16 + int'(record_id) - 1);
                hit.data_position = byte_pos + 16'd1;
                sectors_due.push_back(hit);
              end
            end else if (byte_pos != 16'd0 && below_limit(byte_pos - 16'd1, d.track_length)
                         && d.track_byte == IdMark) begin
              scan_state = PhHeader;
              hdr_cnt = '0;
            end else begin
              scan_state = PhHunt;
            end
          end
        end
        default: scan_state = PhHunt;
      endcase
      if (d.end_of_track) begin
        scan_state = PhHunt;
        hdr_cnt = '0;
        byte_pos = '0;
        if (int'(track_cnt) < MaxTracksDef - 1) track_cnt = track_cnt + 8'd1;
      end else if (byte_pos != 16'hFFFF) begin
        byte_pos = byte_pos + 16'd1;
      end
    endfunction

    function void check_sector(out_item_t got);
      out_item_t want;
      if (sectors_due.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected sector: trk %0d sec %0d slot %0d pos %0d", $realtime,
                   got.track_index, got.sector_number, got.sector_slot, got.data_position);
        mismatches++;
        return;
      end
      want = sectors_due.pop_front();
      if (got.track_index !== want.track_index || got.sector_number !== want.sector_number ||
          got.sector_slot !== want.sector_slot || got.data_position !== want.data_position) begin
        if (mismatches < 10) begin
          $display("%0t: sector mismatch: expected trk %0d sec %0d slot %0d pos %0d,",
                   $realtime, want.track_index, want.sector_number, want.sector_slot,
                   want.data_position);
          $display("  got trk %0d sec %0d slot %0d pos %0d", got.track_index,
                   got.sector_number, got.sector_slot, got.data_position);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i  = '0;

  sector_scoreboard sb;

  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          hold_left     = 0;
  int          cur_ds        = int'(DataSizeRst);
  logic [15:0] cur_tlen      = 16'd0;
  int          track_left    = 1;
  int          tb_pos        = 0;
  int          n_items       = 0;

  mfm_track_sector_locator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_sector(out_data_o);
      if (cfg_valid_i && cfg_ready_o) sb.data_size = cfg_data_i;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void start_track();
    int budget;
    int jitter;
    int lim;
    budget = $urandom_range(15, 260);
    jitter = $urandom_range(0, 120);
    track_left = budget;
    case ($urandom_range(9))
      0: cur_tlen = 16'($urandom);
      1: cur_tlen = 16'($urandom_range(0, 40));
      default: begin
        lim = budget + cur_ds + int'(LimitGap) + jitter - 60;
        if (lim < 0) lim = 0;
        if (lim > 65535) lim = 65535;
        cur_tlen = 16'(lim);
      end
    endcase
  endfunction

  function automatic logic [7:0] sync_byte();
    return ($urandom_range(3) == 0) ? 8'($urandom) : 8'hA1;
  endfunction

  task automatic drive_byte(input in_item_t d);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < in_idle_pct) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic put(input logic [7:0] b, input logic m);
    in_item_t d;
    d.track_byte   = b;
    d.is_mark      = m;
    d.track_length = cur_tlen;
    d.end_of_track = (track_left == 1);
    drive_byte(d);
    n_items++;
    if (d.end_of_track) begin
      tb_pos = 0;
      start_track();
    end else begin
      track_left--;
      if (tb_pos < 65535) tb_pos++;
    end
  endtask

  task automatic put_header(input logic [7:0] cyl, input logic [7:0] head,
                            input logic [7:0] rec, input logic [7:0] size);
    put(cyl, 1'($urandom_range(1)));
    put(head, 1'($urandom_range(1)));
    put(rec, 1'($urandom_range(1)));
    put(size, 1'($urandom_range(1)));
    repeat (2) put(8'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic put_sector();
    logic [7:0] rec;
    logic [7:0] dm;
    logic [7:0] wrong;
    int r;
    repeat ($urandom_range(1, 3)) put(sync_byte(), 1'b1);
    if ($urandom_range(99) < 8) begin
      wrong = 8'($urandom);
      if (wrong == IdMark) wrong = 8'h00;
      put(wrong, 1'b0);
      return;
    end
    put(IdMark, 1'b0);
    do begin
      r = $urandom_range(99);
      if (r < 70) rec = 8'($urandom_range(1, 16));
      else if (r < 80) rec = 8'h00;
      else if (r < 85) rec = 8'd17;
      else rec = 8'($urandom);
      put_header(8'($urandom), 8'($urandom), rec,
                 ($urandom_range(99) < 85) ? SizeCodeOk : 8'($urandom));
      repeat ($urandom_range(0, 3)) put(8'($urandom), 1'b0);
      repeat ($urandom_range(1, 3)) put(sync_byte(), 1'b1);
      r = $urandom_range(99);
      if (r < 45) dm = DataMark;
      else if (r < 80) dm = DelDataMark;
      else if (r < 90) dm = IdMark;
      else dm = 8'($urandom);
      put(dm, 1'b0);
    end while (dm == IdMark);
    repeat ($urandom_range(1, 4)) put(8'($urandom), 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_data_size(input logic [10:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_ds = int'(v);
  endtask

  task automatic overlong_track();
    track_left = 1;
    put(8'($urandom), 1'b0);
    cur_tlen = 16'hFFFF;
    track_left = 1 << 20;
    while (tb_pos < 65000) begin
      repeat ($urandom_range(500, 5000)) put(8'($urandom), 1'b0);
      put_sector();
    end
    while (tb_pos < 65505) put(8'($urandom), 1'b0);
    put(8'hA1, 1'b1);
    put(IdMark, 1'b0);
    put_header(8'h4F, 8'h01, 8'h09, SizeCodeOk);
    while (tb_pos < 65535) put(8'($urandom), 1'b0);
    repeat (3) put(8'($urandom), 1'b0);
    put(8'hA1, 1'b1);
    put(DataMark, 1'b0);
    put(8'h00, 1'b0);
    track_left = 1;
    put(8'h00, 1'b0);
  endtask

  initial begin
    int first;
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    cur_tlen = 16'd300;
    track_left = 33;
    put(8'hA1, 1'b1);
    put(8'h00, 1'b0);
    put(8'hA1, 1'b1);
    put(8'hA1, 1'b1);
    put(IdMark, 1'b0);
    put_header(8'h7F, 8'h80, 8'h01, SizeCodeOk);
    put(8'hA1, 1'b1);
    put(IdMark, 1'b0);
    put_header(8'hFF, 8'hFF, 8'd17, SizeCodeOk);
    put(8'h4E, 1'b0);
    put(8'hA1, 1'b1);
    put(DataMark, 1'b0);
    put(8'hE5, 1'b0);
    put(8'hFF, 1'b1);
    put(IdMark, 1'b0);
    put_header(8'h00, 8'h01, RecordMax, SizeCodeOk);
    put(8'hA1, 1'b1);
    put(DelDataMark, 1'b0);
    cur_tlen = 16'd0;
    track_left = 2;
    put(8'hA1, 1'b1);
    put(IdMark, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_data_size(11'd0);
        1: set_data_size(11'd1024);
        2: set_data_size(11'($urandom_range(1, 1023)));
        default: set_data_size(11'd1023);
      endcase
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 63; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 63; end
        default: begin in_idle_pct = 29; out_stall_pct = 29; end
      endcase
      start_track();
      if (ph == 0) hold_left = 400;
      if (ph == 3) begin
        repeat (260) begin
          track_left = 1;
          put(8'($urandom), 1'($urandom_range(1)));
        end
      end
      first = n_items;
      while (n_items - first < 425) begin
        repeat ($urandom_range(0, 4)) put(8'($urandom), $urandom_range(99) < 15);
        put_sector();
      end
      if (ph == 0) overlong_track();
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mtsl_pkg.sv
design/mtsl_scan.sv
design/mfm_track_sector_locator.sv
tb/tb_mfm_track_sector_locator.sv
